/* rtl/rasmu_pkg.sv */
package rasmu_pkg;

  localparam int WIDTH_DEF = 16;
  localparam int NUM_OUT_W = 33;
  localparam int DEN_OUT_W = 32;

  // command codes; the spare code is decoded as multiply
  localparam logic [1:0] CMD_ADD  = 2'd0;
  localparam logic [1:0] CMD_SUB  = 2'd1;
  localparam logic [1:0] CMD_MUL  = 2'd2;
  localparam logic [1:0] CMD_RSVD = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_GCD,
    ST_DIV_A,
    ST_DIV_B,
    ST_MUL_LCM,
    ST_MUL_TA,
    ST_MUL_TB,
    ST_SUM,
    ST_MUL_NN,
    ST_MUL_DD,
    ST_FIN
  } state_t;

  // shared multiplier operation
  typedef enum logic [2:0] {
    MOP_NONE,
    MOP_LCM,
    MOP_TA,
    MOP_TB,
    MOP_NN,
    MOP_DD
  } mop_t;

  typedef struct packed {
    logic load;       // capture the input transfer
    logic chk_err;    // zero denominator: force error result
    logic gcd_step;
    logic div_load;
    logic div_src_b;  // dividend is den_b
    logic div_step;
    logic save_qa;
    logic save_qb;
    mop_t mop;
    logic sum_en;
    logic out_load;
  } ctrl_t;

  typedef struct packed {
    logic zero_den;
    logic is_mul;
    logic gcd_done;
    logic div_done;
  } stat_t;

endpackage

/* rtl/rasmu_ctrl.sv */
module rasmu_ctrl
  import rasmu_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_stall,
  output logic  out_valid,
  input  logic  out_stall,
  input  stat_t stat,
  output ctrl_t ctrl
);

  state_t state_r, state_nxt;
  logic   out_valid_r;
  logic   out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        priority if (stat.zero_den) state_nxt = ST_FIN;
        else if (stat.is_mul)       state_nxt = ST_MUL_NN;
        else                        state_nxt = ST_GCD;
      end
      ST_GCD: begin
        if (stat.gcd_done) state_nxt = ST_DIV_A;
      end
      ST_DIV_A: begin
        if (stat.div_done) state_nxt = ST_DIV_B;
      end
      ST_DIV_B: begin
        if (stat.div_done) state_nxt = ST_MUL_LCM;
      end
      ST_MUL_LCM: state_nxt = ST_MUL_TA;
      ST_MUL_TA:  state_nxt = ST_MUL_TB;
      ST_MUL_TB:  state_nxt = ST_SUM;
      ST_SUM:     state_nxt = ST_FIN;
      ST_MUL_NN:  state_nxt = ST_MUL_DD;
      ST_MUL_DD:  state_nxt = ST_FIN;
      ST_FIN: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    ctrl = '0;
    ctrl.mop = MOP_NONE;
    unique case (state_r)
      ST_IDLE:  ctrl.load = in_valid;
      ST_CHECK: ctrl.chk_err = stat.zero_den;
      ST_GCD: begin
        if (stat.gcd_done) ctrl.div_load = 1'b1;
        else               ctrl.gcd_step = 1'b1;
      end
      ST_DIV_A: begin
        if (stat.div_done) begin
          ctrl.save_qa   = 1'b1;
          ctrl.div_load  = 1'b1;
          ctrl.div_src_b = 1'b1;
        end else begin
          ctrl.div_step = 1'b1;
        end
      end
      ST_DIV_B: begin
        if (stat.div_done) ctrl.save_qb  = 1'b1;
        else               ctrl.div_step = 1'b1;
      end
      ST_MUL_LCM: ctrl.mop = MOP_LCM;
      ST_MUL_TA:  ctrl.mop = MOP_TA;
      ST_MUL_TB:  ctrl.mop = MOP_TB;
      ST_SUM:     ctrl.sum_en = 1'b1;
      ST_MUL_NN:  ctrl.mop = MOP_NN;
      ST_MUL_DD:  ctrl.mop = MOP_DD;
      ST_FIN:     ctrl.out_load = out_free;
      default: ;
    endcase
  end

endmodule

/* rtl/rasmu_dp.sv */
module rasmu_dp
  import rasmu_pkg::*;
#(
  parameter int WIDTH = WIDTH_DEF
) (
  input  logic                        clk,
  input  ctrl_t                       ctrl,
  output stat_t                       stat,
  input  logic [1:0]                  in_command,
  input  logic signed [WIDTH-1:0]     in_num_a,
  input  logic [WIDTH-1:0]            in_den_a,
  input  logic signed [WIDTH-1:0]     in_num_b,
  input  logic [WIDTH-1:0]            in_den_b,
  output logic signed [NUM_OUT_W-1:0] out_num_result,
  output logic [DEN_OUT_W-1:0]        out_den_result,
  output logic                        out_error
);

  localparam int KW = $clog2(WIDTH + 1);
  localparam int PW = 2 * WIDTH + 2;
  localparam int EW = (PW > NUM_OUT_W) ? PW : NUM_OUT_W;

  // operands
  logic [1:0]       cmd_r;
  logic [WIDTH-1:0] na_r, nb_r, da_r, db_r;

  // binary gcd
  logic [WIDTH-1:0] x_r, y_r;
  logic [KW-1:0]    k_r;

  // restoring divider
  logic [WIDTH-1:0] d_r, q_r, rem_r, qa_r, qb_r;
  logic [KW-1:0]    cnt_r;
  logic [WIDTH:0]   rem_sh, rem_diff;
  logic             rem_ge;

  // multiplier
  logic signed [WIDTH:0]  mul_a, mul_b;
  logic signed [PW-1:0]   prod;
  logic signed [EW-1:0]   prod_ext;

  // results
  logic [NUM_OUT_W-1:0] ta_r, tb_r, num_r;
  logic [DEN_OUT_W-1:0] den_r;
  logic                 err_r;
  logic [NUM_OUT_W-1:0] out_num_r;
  logic [DEN_OUT_W-1:0] out_den_r;
  logic                 out_err_r;

  assign stat.zero_den = (da_r == '0) || (db_r == '0);
  assign stat.is_mul   = (cmd_r == CMD_MUL) || (cmd_r == CMD_RSVD);
  assign stat.gcd_done = (x_r == y_r);
  assign stat.div_done = (cnt_r == '0);

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd_r <= in_command;
      na_r  <= in_num_a;
      nb_r  <= in_num_b;
      da_r  <= in_den_a;
      db_r  <= in_den_b;
      x_r   <= in_den_a;
      y_r   <= in_den_b;
      k_r   <= '0;
    end else if (ctrl.gcd_step) begin
      priority if (!x_r[0] && !y_r[0]) begin
        x_r <= x_r >> 1;
        y_r <= y_r >> 1;
        k_r <= k_r + 1'b1;
      end else if (!x_r[0]) begin
        x_r <= x_r >> 1;
      end else if (!y_r[0]) begin
        y_r <= y_r >> 1;
      end else if (x_r > y_r) begin
        x_r <= x_r - y_r;
      end else begin
        y_r <= y_r - x_r;
      end
    end
  end

  assign rem_sh   = {rem_r, q_r[WIDTH-1]};
  assign rem_diff = rem_sh - {1'b0, d_r};
  assign rem_ge   = (rem_sh >= {1'b0, d_r});

  always_ff @(posedge clk) begin
    if (ctrl.div_load) begin
      if (!ctrl.div_src_b) d_r <= x_r << k_r;
      q_r   <= ctrl.div_src_b ? db_r : da_r;
      rem_r <= '0;
      cnt_r <= KW'(WIDTH);
    end else if (ctrl.div_step) begin
      rem_r <= rem_ge ? rem_diff[WIDTH-1:0] : rem_sh[WIDTH-1:0];
      q_r   <= {q_r[WIDTH-2:0], rem_ge};
      cnt_r <= cnt_r - 1'b1;
    end
    if (ctrl.save_qa) qa_r <= q_r;
    if (ctrl.save_qb) qb_r <= q_r;
  end

  always_comb begin
    unique case (ctrl.mop)
      MOP_LCM: begin
        mul_a = {1'b0, qa_r};
        mul_b = {1'b0, db_r};
      end
      MOP_TA: begin
        mul_a = {na_r[WIDTH-1], na_r};
        mul_b = {1'b0, qb_r};
      end
      MOP_TB: begin
        mul_a = {nb_r[WIDTH-1], nb_r};
        mul_b = {1'b0, qa_r};
      end
      MOP_NN: begin
        mul_a = {na_r[WIDTH-1], na_r};
        mul_b = {nb_r[WIDTH-1], nb_r};
      end
      MOP_DD: begin
        mul_a = {1'b0, da_r};
        mul_b = {1'b0, db_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod     = PW'(mul_a) * PW'(mul_b);
  assign prod_ext = EW'(prod);

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      err_r <= 1'b0;
    end else if (ctrl.chk_err) begin
      err_r <= 1'b1;
      num_r <= '0;
      den_r <= '0;
    end else if (ctrl.sum_en) begin
      num_r <= (cmd_r == CMD_SUB) ? (ta_r - tb_r) : (ta_r + tb_r);
    end else begin
      unique case (ctrl.mop)
        MOP_LCM: den_r <= prod_ext[DEN_OUT_W-1:0];
        MOP_TA:  ta_r  <= prod_ext[NUM_OUT_W-1:0];
        MOP_TB:  tb_r  <= prod_ext[NUM_OUT_W-1:0];
        MOP_NN:  num_r <= prod_ext[NUM_OUT_W-1:0];
        MOP_DD:  den_r <= prod_ext[DEN_OUT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      out_num_r <= num_r;
      out_den_r <= den_r;
      out_err_r <= err_r;
    end
  end

  assign out_num_result = out_num_r;
  assign out_den_result = out_den_r;
  assign out_error      = out_err_r;

endmodule

/* rtl/rational_add_sub_mul_unit_top.sv */
// A zero denominator goes from the check straight to the result; multiply forms two products.
// Add/subtract also run the binary gcd loop, whose length depends on the operands, and two
// restoring divisions before the three products and the sum.
// One item at a time: a new input transfer is taken only when the sequencer is idle again.
// A new input transfer is taken while the previous result still waits in the output register.
// Reset: synchronous active-low rst_n clears the controller and the output valid.
module rational_add_sub_mul_unit_top
  import rasmu_pkg::*;
#(
  parameter int WIDTH = WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // input channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_command,
  input  logic signed [WIDTH-1:0]     in_num_a,
  input  logic [WIDTH-1:0]            in_den_a,
  input  logic signed [WIDTH-1:0]     in_num_b,
  input  logic [WIDTH-1:0]            in_den_b,
  // result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [NUM_OUT_W-1:0] out_num_result,
  output logic [DEN_OUT_W-1:0]        out_den_result,
  output logic                        out_error
);

  ctrl_t ctrl;
  stat_t stat;

  // Sequencer: check for zero denominators (error result at once), then
  // either two products (multiply) or gcd -> den_a/g -> den_b/g -> lcm
  // and the two scaled numerators -> sum/difference. The result is then
  // moved into the output register once that register is free.
  rasmu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .ctrl      (ctrl)
  );

  // Operand registers, binary gcd, restoring divider, one shared
  // (WIDTH+1)x(WIDTH+1) signed multiplier and the output register.
  // lcm = (den_a/g)*den_b; numerators scale by den_b/g and den_a/g.
  rasmu_dp #(
    .WIDTH (WIDTH)
  ) u_dp (
    .clk            (clk),
    .ctrl           (ctrl),
    .stat           (stat),
    .in_command     (in_command),
    .in_num_a       (in_num_a),
    .in_den_a       (in_den_a),
    .in_num_b       (in_num_b),
    .in_den_b       (in_den_b),
    .out_num_result (out_num_result),
    .out_den_result (out_den_result),
    .out_error      (out_error)
  );

endmodule
